FILE: rtl/lfuct_pkg.sv
// Shared types and constants for the LFU cache table.
`default_nettype none
package lfuct_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CAP_REG_W  = 5;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  // Request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // Register index, taken from the word address
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_CAPACITY = 1'b0;

  // Outcome of one transaction
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/lfuct_cfg.sv
// APB register block holding the capacity_in_use register.
`default_nettype none
module lfuct_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lfuct_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [lfuct_pkg::DATA_W-1:0]      pwdata,
  output logic      [lfuct_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready,
  output logic      [lfuct_pkg::CAP_REG_W-1:0]   cap
);
  import lfuct_pkg::*;

  logic [CAP_REG_W-1:0] cap_r;
  logic [CAP_REG_W-1:0] cap_nxt;
  reg_idx_t             reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cap     = cap_r;

  always_comb begin
    cap_nxt = cap_r;
    prdata  = '0;
    unique case (reg_idx)
      REG_CAPACITY: begin
        prdata = {{(DATA_W-CAP_REG_W){1'b0}}, cap_r};
        if (wr_en) begin
          cap_nxt = pwdata[CAP_REG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lfuct_victim_sel.sv
// Min tree picking the lowest-count, oldest valid entry.
`default_nettype none
module lfuct_victim_sel #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int RANK_W      = 4,
  parameter int IDX_W       = 4
) (
  input  wire logic [CAPACITY-1:0]    valid,
  input  wire logic [COUNT_WIDTH-1:0] count [CAPACITY],
  input  wire logic [RANK_W-1:0]      rank  [CAPACITY],
  output logic                        found,
  output logic      [IDX_W-1:0]       idx
);

  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int KEY_W  = COUNT_WIDTH + RANK_W;

  // Heap layout: node n has children 2n+1 and 2n+2, leaves at LEAVES-1+k
  logic             nv [NODES];
  logic [KEY_W-1:0] nk [NODES];
  logic [IDX_W-1:0] ni [NODES];

  genvar k, n;
  generate
    for (k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < CAPACITY) begin : g_real
        // lower count wins, then higher rank (older) via inverted rank
        assign nv[LEAVES-1+k] = valid[k];
        assign nk[LEAVES-1+k] = {count[k], ~rank[k]};
      end else begin : g_pad
        assign nv[LEAVES-1+k] = 1'b0;
        assign nk[LEAVES-1+k] = '0;
      end
      assign ni[LEAVES-1+k] = IDX_W'(k);
    end
    for (n = 0; n < LEAVES - 1; n++) begin : g_node
      logic take_l;
      assign take_l = nv[2*n+1] && (!nv[2*n+2] || (nk[2*n+1] <= nk[2*n+2]));
      assign nv[n]  = nv[2*n+1] || nv[2*n+2];
      assign nk[n]  = take_l ? nk[2*n+1] : nk[2*n+2];
      assign ni[n]  = take_l ? ni[2*n+1] : ni[2*n+2];
    end
  endgenerate

  assign found = nv[0];
  assign idx   = ni[0];

endmodule
`default_nettype wire

FILE: rtl/lfuct_table.sv
// Entry store with parallel lookup, LFU/LRU replacement and rank upkeep.
`default_nettype none
module lfuct_table #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int RANK_W      = 4,
  parameter int IDX_W       = 4,
  parameter int HELD_W      = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            go,
  input  wire logic                            mode,
  input  wire logic [lfuct_pkg::DATA_W-1:0]    key,
  input  wire logic [lfuct_pkg::DATA_W-1:0]    new_value,
  input  wire logic [lfuct_pkg::CAP_REG_W-1:0] cap,
  output lfuct_pkg::result_t                   result
);
  import lfuct_pkg::*;

  localparam int CMP_W = (HELD_W > CAP_REG_W) ? HELD_W : CAP_REG_W;

  logic [CAPACITY-1:0]    valid_r, valid_nxt;
  logic [DATA_W-1:0]      key_r     [CAPACITY];
  logic [DATA_W-1:0]      key_nxt   [CAPACITY];
  logic [DATA_W-1:0]      value_r   [CAPACITY];
  logic [DATA_W-1:0]      value_nxt [CAPACITY];
  logic [COUNT_WIDTH-1:0] count_r   [CAPACITY];
  logic [COUNT_WIDTH-1:0] count_nxt [CAPACITY];
  logic [RANK_W-1:0]      rank_r    [CAPACITY];
  logic [RANK_W-1:0]      rank_nxt  [CAPACITY];
  logic [HELD_W-1:0]      held_r, held_nxt;

  logic [CAPACITY-1:0] hit_vec, vic_oh, valid_after, free_vec, ins_oh;
  logic                hit_any, full, set_miss, evict, insert;
  logic [RANK_W-1:0]   hit_rank, vic_rank;
  logic [DATA_W-1:0]   hit_value, vic_key;
  logic                vic_found;
  logic [IDX_W-1:0]    vic_idx;

  lfuct_victim_sel #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH),
    .RANK_W      (RANK_W),
    .IDX_W       (IDX_W)
  ) u_victim (
    .valid (valid_r),
    .count (count_r),
    .rank  (rank_r),
    .found (vic_found),
    .idx   (vic_idx)
  );

  assign vic_rank = rank_r[vic_idx];
  assign vic_key  = key_r[vic_idx];

  // Lookup: keys are unique among valid entries, so OR-muxing is exact
  always_comb begin
    hit_vec   = '0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == key);
      if (hit_vec[i]) begin
        hit_rank  = hit_rank | rank_r[i];
        hit_value = hit_value | value_r[i];
      end
    end
  end

  assign hit_any = |hit_vec;

  // held >= min(cap, CAPACITY); held never exceeds CAPACITY
  assign full = (CMP_W'(held_r) >= CMP_W'(cap)) || (held_r == HELD_W'(CAPACITY));

  assign set_miss = go && (mode == MODE_SET) && !hit_any && (cap != '0);
  assign evict    = set_miss && full && vic_found;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vic_oh[i] = evict && (vic_idx == IDX_W'(i));
    end
  end

  assign valid_after = valid_r & ~vic_oh;
  assign free_vec    = ~valid_after;
  assign ins_oh      = free_vec & (~free_vec + CAPACITY'(1));  // lowest free slot
  assign insert      = set_miss && (|ins_oh);

  always_comb begin
    valid_nxt = valid_r;
    held_nxt  = held_r;
    for (int i = 0; i < CAPACITY; i++) begin
      key_nxt[i]   = key_r[i];
      value_nxt[i] = value_r[i];
      count_nxt[i] = count_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    if (go && hit_any) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
          if (count_r[i] != '1) begin
            count_nxt[i] = count_r[i] + COUNT_WIDTH'(1);
          end
          if (mode == MODE_SET) begin
            value_nxt[i] = new_value;
          end
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end else begin
      valid_nxt = valid_after;
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_after[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(insert)
                      - RANK_W'(evict && (rank_r[i] > vic_rank));
        end
        if (insert && ins_oh[i]) begin
          valid_nxt[i] = 1'b1;
          key_nxt[i]   = key;
          value_nxt[i] = new_value;
          count_nxt[i] = COUNT_WIDTH'(1);
          rank_nxt[i]  = '0;
        end
      end
      held_nxt = held_r + HELD_W'(insert) - HELD_W'(evict);
    end
  end

  always_comb begin
    result.hit         = hit_any;
    result.evicted     = evict;
    result.evicted_key = evict ? vic_key : '0;
    if (mode == MODE_SET) begin
      result.read_value = '0;
    end else if (hit_any) begin
      result.read_value = hit_value;
    end else begin
      result.read_value = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      held_r  <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      held_r  <= held_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_r[i]   <= key_nxt[i];
      value_r[i] <= value_nxt[i];
      count_r[i] <= count_nxt[i];
    end
  end

  a_held_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(held_r))
    else $error("held count does not match valid entries");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_W'(CAPACITY))
    else $error("held count exceeds table size");

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (go && hit_any) |-> (!evict && !insert))
    else $error("replacement on a hit");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (insert && !evict) |=> (held_r == $past(held_r) + HELD_W'(1)))
    else $error("insert without eviction did not grow the table");

endmodule
`default_nettype wire

FILE: rtl/lfu_cache_table_core.sv
// Top level of the LFU cache table: command port, APB registers, result register.
`default_nettype none
// Fully associative key/value cache, CAPACITY entries, least-frequently-used
// replacement with least-recently-used tie-break. A transaction is taken on
// any edge with start high and busy low; busy is never raised, so a new
// transaction may be issued every clock. The request is registered, looked
// up against all entries in parallel, the victim is chosen by a min tree over
// {use count, age}, and the outcome lands in the result register, where
// out_valid rises and stays high for one cycle. The receiver cannot stall;
// it must take each result in the cycle it is shown. One table update per
// clock sets the rate: one transaction per cycle.
// capacity_in_use (APB byte address 0, reset 16) limits how many entries are
// held; zero stops new inserts while hits still work. Only write it while no
// transaction is in flight. Use counts saturate at 2^COUNT_WIDTH-1.
module lfu_cache_table_core #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // command channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_mode,
  input  wire logic signed [lfuct_pkg::DATA_W-1:0]   in_key,
  input  wire logic signed [lfuct_pkg::DATA_W-1:0]   in_new_value,
  // result channel
  output logic                                       out_valid,
  output logic                                       out_hit,
  output logic signed      [lfuct_pkg::DATA_W-1:0]   out_read_value,
  output logic                                       out_evicted,
  output logic signed      [lfuct_pkg::DATA_W-1:0]   out_evicted_key,
  // APB configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic        [lfuct_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic        [lfuct_pkg::DATA_W-1:0]   pwdata,
  output logic             [lfuct_pkg::DATA_W-1:0]   prdata,
  output logic                                       pready
);
  import lfuct_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int HELD_W = $clog2(CAPACITY + 1);

  logic                 req_valid_r;
  logic                 req_mode_r;
  logic [DATA_W-1:0]    req_key_r;
  logic [DATA_W-1:0]    req_value_r;
  logic                 accept;

  logic [CAP_REG_W-1:0] cap;
  result_t              result;

  logic                 res_valid_r;
  result_t              res_r;

  // Nothing ever stalls the front end
  assign busy   = 1'b0;
  assign accept = start && !busy;

  lfuct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  lfuct_table #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH),
    .RANK_W      (RANK_W),
    .IDX_W       (IDX_W),
    .HELD_W      (HELD_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (req_valid_r),
    .mode      (req_mode_r),
    .key       (req_key_r),
    .new_value (req_value_r),
    .cap       (cap),
    .result    (result)
  );

  // Request register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r  <= in_mode;
      req_key_r   <= in_key;
      req_value_r <= in_new_value;
    end
    if (req_valid_r) begin
      res_r <= result;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_hit         = res_r.hit;
  assign out_read_value  = res_r.read_value;
  assign out_evicted     = res_r.evicted;
  assign out_evicted_key = res_r.evicted_key;

endmodule
`default_nettype wire
